[rtl/core/wbps_pkg.sv]
// Shared types, constants and the byte compare function of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 16;
  localparam int unsigned WINDOW_DEPTH      = 15;
  localparam int unsigned OFFSET_BITS       = 32;
  localparam int unsigned ADDR_BITS         = 48;
  localparam int unsigned LEN_BITS          = 5;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS     = 64;
  localparam int unsigned IDX_BITS          = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned CARE_BITS         = MAX_PATTERN_BYTES;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_BASE  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } scan_req_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] match_address;
  } result_req_t;

  // Pattern byte and care flag that apply at one window position.
  typedef struct packed {
    logic [7:0] pat;
    logic       care;
  } pat_sel_t;

  // A position passes when it is a wildcard or the byte equals the pattern byte.
  function automatic logic byte_ok(input logic [7:0] data, input pat_sel_t sel);
    byte_ok = ~sel.care | (data == sel.pat);
  endfunction

endpackage

[rtl/core/wildcard_byte_pattern_scanner.sv]
// Top level of the wildcard byte pattern scanner: config registers, cell chain, result pipeline.
//
// The scanner takes a memory region one byte per request and compares the newest
// byte plus the fifteen bytes before it with a pattern of up to sixteen bytes, where
// positions whose care bit is clear are wildcards. The first full match in a region
// yields one result with found set and the region base plus the match's start
// offset; after that the block stays quiet until the region's last byte. A region
// that ends with no match yields one result with found clear and address zero. A
// byte is accepted every clock cycle while the output is not stalled: the window is a
// chain of fifteen cells that shift in the same cycle as they compare, so the
// sustained rate is one byte per cycle unless a full result pipeline is stalled.
// A result passes through one stage that forms the match offset and an output
// register that adds the region base. Configuration writes are always ready and
// take effect on the next byte; they are to be made while no result is pending.
module wildcard_byte_pattern_scanner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Byte requests.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wbps_pkg::scan_req_t                 in_req_i,
  // Result requests.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wbps_pkg::result_req_t               out_req_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import wbps_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [63:0]          pat_low_q;
  logic [63:0]          pat_high_q;
  logic [CARE_BITS-1:0] care_q;
  logic [LEN_BITS-1:0]  len_cfg_q;
  logic [ADDR_BITS-1:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '1;
      len_cfg_q  <= LEN_BITS'(1);
      base_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_data_i[63:0];
        CFG_PATTERN_HIGH: pat_high_q <= cfg_data_i[63:0];
        CFG_CARE_MASK:    care_q     <= cfg_data_i[CARE_BITS-1:0];
        CFG_PATTERN_LEN:  len_cfg_q  <= cfg_data_i[LEN_BITS-1:0];
        CFG_REGION_BASE:  base_q     <= cfg_data_i[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the pattern capacity act as the full capacity.
  logic [LEN_BITS-1:0] len_eff;
  assign len_eff = (len_cfg_q > LEN_BITS'(MAX_PATTERN_BYTES)) ?
                   LEN_BITS'(MAX_PATTERN_BYTES) : len_cfg_q;

  // ---------------------------------------------------------------------------
  // Per-position pattern selection. Position d holds the byte seen d requests
  // ago; it lines up with pattern byte len-1-d and takes part only when d < len.
  // ---------------------------------------------------------------------------
  logic [8*MAX_PATTERN_BYTES-1:0] pat_flat;
  pat_sel_t                       sel [MAX_PATTERN_BYTES];

  assign pat_flat = {pat_high_q, pat_low_q};

  always_comb begin
    logic [LEN_BITS-1:0] k;
    logic                in_use;
    for (int d = 0; d < MAX_PATTERN_BYTES; d++) begin
      k          = len_eff - LEN_BITS'(1) - LEN_BITS'(d);
      in_use     = LEN_BITS'(d) < len_eff;
      sel[d].pat  = pat_flat[8*k[IDX_BITS-1:0] +: 8];
      sel[d].care = in_use & care_q[k[IDX_BITS-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Window: the newest byte is compared straight from the request, the older
  // ones from the cell chain.
  // ---------------------------------------------------------------------------
  logic                         in_fire;
  logic                         region_end;
  logic [7:0]                   chain [WINDOW_DEPTH+1];
  logic [MAX_PATTERN_BYTES-1:0] pos_hit;

  assign in_fire    = in_valid_i & ~in_stall_o;
  assign region_end = in_fire & in_req_i.last_byte;
  assign chain[0]   = in_req_i.data_byte;
  assign pos_hit[0] = byte_ok(in_req_i.data_byte, sel[0]);

  for (genvar c = 0; c < WINDOW_DEPTH; c++) begin : g_cell
    wbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_fire),
      .clear_i (region_end),
      .byte_i  (chain[c]),
      .sel_i   (sel[c+1]),
      .byte_o  (chain[c+1]),
      .hit_o   (pos_hit[c+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Region tracking: saturating byte count and the reported flag.
  // ---------------------------------------------------------------------------
  logic [OFFSET_BITS-1:0] count_q, count_d, count_inc;
  logic                   reported_q, reported_d;
  logic                   enough, hit, emit;

  assign count_inc = (count_q == '1) ? count_q : count_q + OFFSET_BITS'(1);
  assign enough    = (len_eff != '0) && (count_inc >= OFFSET_BITS'(len_eff));
  assign hit       = ~reported_q & enough & (&pos_hit);
  assign emit      = hit | (in_req_i.last_byte & ~reported_q);

  always_comb begin
    count_d    = count_q;
    reported_d = reported_q;
    if (in_fire) begin
      if (in_req_i.last_byte) begin
        count_d    = '0;
        reported_d = 1'b0;
      end else begin
        count_d    = count_inc;
        reported_d = reported_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      reported_q <= reported_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result pipeline. Stage one holds found and the start offset; the output
  // register adds the region base. A stage takes new data when it is empty or
  // its contents move on in the same cycle.
  // ---------------------------------------------------------------------------
  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_found_q;
  logic [OFFSET_BITS-1:0] s1_offset_q;
  logic                   out_valid_q, out_valid_d;
  result_req_t            out_req_q;
  logic                   out_free, s1_free, s1_adv;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_adv     = s1_valid_q & out_free;
  assign s1_free    = ~s1_valid_q | out_free;
  assign in_stall_o = ~s1_free;

  assign s1_valid_d  = s1_free ? (in_fire & emit) : s1_valid_q;
  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      s1_found_q  <= hit;
      s1_offset_q <= hit ? (count_inc - OFFSET_BITS'(len_eff)) : '0;
    end
    if (s1_adv) begin
      out_req_q.found         <= s1_found_q;
      out_req_q.match_address <= s1_found_q ? (base_q + ADDR_BITS'(s1_offset_q)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

[rtl/core/wbps_cell.sv]
// One window cell: holds one past byte, hands it to the next cell and compares it.
module wbps_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 clear_i,
  input  logic [7:0]           byte_i,
  input  wbps_pkg::pat_sel_t   sel_i,
  output logic [7:0]           byte_o,
  output logic                 hit_o
);
  import wbps_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = 8'd0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = byte_ok(byte_q, sel_i);

endmodule

[tb/sv/wildcard_byte_pattern_scanner_tb.sv]
// Self-checking testbench for the wildcard byte pattern scanner.
module wildcard_byte_pattern_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  // The scanner passes each result through stage one and the output register.
  // Extra cycles after the last expected result make sure that nothing is
  // still in flight before a register is rewritten or the run ends.
  localparam int unsigned DRAIN_CYCLES = 4;
  // 25 directed bytes are followed by roughly 750 random ones.
  localparam int unsigned TOTAL_BYTES  = 775;
  localparam int unsigned PHASE_BYTES  = 64;
  localparam int unsigned DIR_ROWS     = 18;
  localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;
  // Register indexes past the end of the list must be ignored by the block.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_FIRST = CFG_REGION_BASE + 3'd1;

  typedef enum logic {ROW_CONFIG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // One line of the directed table: either a register write or a run of equal
  // bytes whose final byte carries the typed-in result.
  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  value;
    logic [7:0]                data;
    logic                      last;
    logic [4:0]                count;
    logic                      has_result;
    result_req_t               result;
  } step_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  scan_req_t                 in_req    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  result_req_t               out_req;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // Shadow copy of the configuration registers, as last written.
  logic [63:0]          pattern_lo  = '0;
  logic [63:0]          pattern_hi  = '0;
  logic [15:0]          care_bits   = 16'hFFFF;
  logic [4:0]           pattern_len = 5'd1;
  logic [ADDR_BITS-1:0] base_addr   = '0;

  // Shadow copy of the scan state: entry 0 of the window is the newest byte.
  logic [7:0]  recent_bytes [WINDOW_DEPTH];
  logic [31:0] region_count = '0;
  bit          match_done   = 1'b0;

  result_req_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b0;
  bit          busy           = 1'b0;

  step_row_t directed_rows [DIR_ROWS];

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  logic [2:0]  stall_tick = '0;

  wildcard_byte_pattern_scanner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the scanner hangs or drops a result; the slowest legal
  // run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Computes the result, if any, that one accepted byte causes, and moves the
  // shadow scan state forward by that byte.
  task automatic predict_scan_result(input scan_req_t req, output bit has,
                                     output result_req_t res);
    int unsigned  len;
    logic [31:0]  cnt;
    bit           hit;
    logic [7:0]   seen_byte;
    logic [127:0] pat_all;
    len = pattern_len;
    if (len > MAX_PATTERN_BYTES) begin
      len = MAX_PATTERN_BYTES;
    end
    cnt = region_count;
    if (cnt != '1) begin
      cnt++;
    end
    pat_all = {pattern_hi, pattern_lo};
    hit = 1'b0;
    // The compare covers the new byte plus the len-1 bytes before it; it only
    // runs once the region holds enough bytes and no match was reported yet.
    if (!match_done && len != 0 && cnt >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        seen_byte = (k == len - 1) ? req.data_byte : recent_bytes[len - 2 - k];
        if (care_bits[k] && seen_byte != pat_all[8*k +: 8]) begin
          hit = 1'b0;
        end
      end
    end
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
      recent_bytes[i] = recent_bytes[i-1];
    end
    recent_bytes[0] = req.data_byte;
    region_count = cnt;
    has = 1'b0;
    res = '0;
    if (hit) begin
      has = 1'b1;
      res.found = 1'b1;
      // The start offset is added modulo the address width.
      res.match_address = base_addr + ADDR_BITS'(cnt - len);
      match_done = 1'b1;
    end else if (req.last_byte && !match_done) begin
      has = 1'b1;
    end
    // The region's last byte starts a fresh region afterwards.
    if (req.last_byte) begin
      recent_bytes = '{default: 8'h00};
      region_count = '0;
      match_done = 1'b0;
    end
  endtask

  // Offers one byte request, holds it until it is taken, then records the
  // expected result. Valid stays high so that back-to-back bytes need no
  // extra cycle; pace() and drain() lower it.
  task automatic send_byte(input logic [7:0] d, input logic lst, input bit typed,
                           input bit typed_has, input result_req_t typed_res);
    scan_req_t   req;
    bit          has;
    result_req_t res;
    req.data_byte = d;
    req.last_byte = lst;
    in_valid <= 1'b1;
    in_req   <= req;
    busy = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_scan_result(req, has, res);
    // Directed rows carry their own expectation; the shadow state still advances.
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) begin
      pending_results.insert(pending_results.size(), res);
    end
    bytes_sent++;
  endtask

  // Burst pacing on the byte side: a gap when gaps are on, then a burst of random length.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stops sending and waits until every expected result has arrived, plus a
  // margin for bytes that cause no result but may still be in the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    busy = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the shadow copy follows the block's field masking.
  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_PATTERN_LOW:  pattern_lo  = value;
      CFG_PATTERN_HIGH: pattern_hi  = value;
      CFG_CARE_MASK:    care_bits   = value[15:0];
      CFG_PATTERN_LEN:  pattern_len = value[4:0];
      CFG_REGION_BASE:  base_addr   = value[ADDR_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a whole setting. The unused upper bits of the narrow registers get
  // junk to show that the block drops them, and one write goes to an index
  // that does not exist.
  task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] care, input logic [4:0] len,
                               input logic [ADDR_BITS-1:0] base);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_write(CFG_PATTERN_LOW, lo);
    cfg_write(CFG_PATTERN_HIGH, hi);
    cfg_write(CFG_CARE_MASK, {junk[63:16], care});
    cfg_write(CFG_PATTERN_LEN, {junk[58:0], len});
    cfg_write(CFG_REGION_BASE, {junk[15:0], base});
    cfg_write(CFG_UNUSED_FIRST + 3'($urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  // Sends one region. Most regions get the pattern planted at a random spot
  // (wildcard positions stay random), some get a copy with one pattern byte
  // flipped in one bit, and some get a second copy at a random spot of its own.
  task automatic scan_region();
    int unsigned  rlen;
    int unsigned  plen;
    int unsigned  pos;
    int unsigned  k;
    int unsigned  roll;
    logic [7:0]   region [64];
    logic [127:0] pat_all;
    pat_all = {pattern_hi, pattern_lo};
    plen = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pattern_len;
    roll = $urandom_range(0, 19);
    if (roll < 14) begin
      rlen = $urandom_range(1, 24);
    end else if (roll < 19) begin
      rlen = $urandom_range(25, 48);
    end else begin
      rlen = 64;
    end
    // A narrow alphabet drawn from the pattern itself gives accidental and
    // partial matches as well.
    roll = $urandom_range(0, 2);
    for (int i = 0; i < rlen; i++) begin
      region[i] = (roll == 0) ? pat_all[8*$urandom_range(0, 15) +: 8] : 8'($urandom);
    end
    for (int copy = 0; copy < 2; copy++) begin
      if (plen != 0 && plen <= rlen && $urandom_range(0, 9) < ((copy == 0) ? 7 : 2)) begin
        pos = $urandom_range(0, rlen - plen);
        for (int j = 0; j < plen; j++) begin
          if (care_bits[j]) begin
            region[pos + j] = pat_all[8*j +: 8];
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, plen - 1);
          region[pos + k] = region[pos + k] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
    end
    for (int i = 0; i < rlen; i++) begin
      pace();
      send_byte(region[i], i == rlen - 1, 1'b0, 1'b0, '0);
    end
  endtask

  function automatic step_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [63:0] value);
    cfg_row = '0;
    cfg_row.kind  = ROW_CONFIG;
    cfg_row.index = idx;
    cfg_row.value = value;
  endfunction

  function automatic step_row_t byte_row(input logic [7:0] d, input logic lst,
                                         input logic [4:0] cnt, input logic has,
                                         input logic found,
                                         input logic [ADDR_BITS-1:0] addr);
    byte_row = '0;
    byte_row.kind                 = ROW_BYTE;
    byte_row.data                 = d;
    byte_row.last                 = lst;
    byte_row.count                = cnt;
    byte_row.has_result           = has;
    byte_row.result.found         = found;
    byte_row.result.match_address = addr;
  endfunction

  // The receiver changes its stall habit every so often: never, now and then,
  // mostly, or on a fixed beat.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 3'd1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick < 3'd3);
    endcase
  end

  // Every result request taken is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected: found %0b address %h",
                 $time, out_req.found, out_req.match_address);
      end else begin
        want = pending_results.pop_front();
        if (out_req.found !== want.found) begin
          mismatch_count++;
          $display("%0t: found expected %0b actual %0b",
                   $time, want.found, out_req.found);
        end
        if (out_req.match_address !== want.match_address) begin
          mismatch_count++;
          $display("%0t: match_address expected %h actual %h",
                   $time, want.match_address, out_req.match_address);
        end
      end
    end
  end

  initial begin
    int unsigned          phase;
    int unsigned          phase_start;
    int unsigned          roll;
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [15:0]          care;
    logic [4:0]           len;
    logic [ADDR_BITS-1:0] base;
    bit                   last_rep;

    recent_bytes = '{default: 8'h00};

    // Directed part. It starts from the reset values: pattern byte 0 is 0x00,
    // length one, every byte cared for, region base zero.
    directed_rows = '{
      // A single zero byte matches at once at offset zero.
      byte_row(8'h00, 1'b1 & 1'b0, 5'd1, 1'b1, 1'b1, '0),
      // After a match the region's last byte stays silent.
      byte_row(8'hFF, 1'b1, 5'd1, 1'b0, 1'b0, '0),
      // A region of one byte that does not match ends not found.
      byte_row(8'hFF, 1'b1, 5'd1, 1'b1, 1'b0, '0),
      // Full-length pattern of all ones, every position a wildcard, top base.
      cfg_row(CFG_PATTERN_LOW, '1),
      cfg_row(CFG_PATTERN_HIGH, '1),
      cfg_row(CFG_CARE_MASK, 64'h0),
      cfg_row(CFG_PATTERN_LEN, 64'd16),
      cfg_row(CFG_REGION_BASE, {16'h0, ADDR_MAX}),
      // A region shorter than the pattern can never match.
      byte_row(8'h00, 1'b1, 5'd1, 1'b1, 1'b0, '0),
      // Sixteen bytes complete the window exactly on the region's last byte.
      byte_row(8'hFF, 1'b0, 5'd15, 1'b0, 1'b0, '0),
      byte_row(8'h00, 1'b1, 5'd1, 1'b1, 1'b1, ADDR_MAX),
      // A zero length never matches.
      cfg_row(CFG_PATTERN_LEN, 64'd0),
      byte_row(8'h5A, 1'b0, 5'd2, 1'b0, 1'b0, '0),
      byte_row(8'hA5, 1'b1, 5'd1, 1'b1, 1'b0, '0),
      // One cared byte of 0xFF found at offset one wraps past the top address.
      cfg_row(CFG_CARE_MASK, 64'hFFFF),
      cfg_row(CFG_PATTERN_LEN, 64'd1),
      byte_row(8'h00, 1'b0, 5'd1, 1'b0, 1'b0, '0),
      byte_row(8'hFF, 1'b1, 5'd1, 1'b1, 1'b1, '0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        if (busy) begin
          drain();
        end
        cfg_write(directed_rows[r].index, directed_rows[r].value);
      end else begin
        for (int rep = 0; rep < directed_rows[r].count; rep++) begin
          last_rep = (rep == directed_rows[r].count - 1);
          send_byte(directed_rows[r].data, directed_rows[r].last && last_rep, 1'b1,
                    directed_rows[r].has_result && last_rep, directed_rows[r].result);
        end
      end
    end

    // Random part: phases of regions, each phase under a fresh setting. The
    // first phases pin the extremes; later ones mix lengths, masks and bases.
    phase = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      roll = $urandom_range(0, 3);
      care = (roll == 0) ? 16'hFFFF :
             (roll == 1) ? 16'($urandom) : 16'($urandom) | 16'($urandom);
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      end else if (roll < 4) begin
        len = 5'($urandom_range(9, 16));
      end else begin
        len = 5'($urandom_range(1, 8));
      end
      roll = $urandom_range(0, 5);
      base = (roll == 0) ? ADDR_MAX : (roll == 1) ? '0 : {16'($urandom), 32'($urandom)};
      case (phase)
        0: begin
          care = 16'hFFFF;
          len  = 5'd16;
          base = ADDR_MAX;
        end
        1: begin
          care = 16'h0000;
          len  = 5'd1;
          base = '0;
        end
        2: len = 5'd0;
        3: len = 5'($urandom_range(17, 31));
        4: len = 5'd31;
        default: ;
      endcase
      // Registers change only while the scanner holds nothing in flight.
      if (busy) begin
        drain();
      end
      apply_setting(lo, hi, care, len, base);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < TOTAL_BYTES) begin
        scan_region();
        // Now and then the sender holds off until every result is back.
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end
      end
      phase++;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
